FILE: hw/rtl/sgle_pkg.sv
// Shared types, codes and fixed-point constants of the sparse-grid evaluator.
package sgle_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int MAX_LEVEL       = 12;
    localparam int DIMS            = 5;
    localparam int LEVEL_W         = 4;
    localparam int INDEX_W         = 12;
    localparam int COORD_W         = 16;
    localparam int SLOT_W          = 12;
    localparam int HAT_W           = COORD_FRAC_BITS + 1;
    localparam int POS_W           = COORD_W + MAX_LEVEL;
    localparam int WEIGHT_W        = 32;
    localparam int TERM_W          = WEIGHT_W + HAT_W + 1 - COORD_FRAC_BITS;
    localparam int VALUE_W         = 48;
    localparam int ACC_W           = VALUE_W + 1;
    localparam int GRID_COUNT_W    = 13;
    localparam int ADDR_W          = 3;
    localparam int DATA_W          = 32;
    localparam int DRAIN_W         = 4;
    localparam int DRAIN_CYCLES    = 8;

    localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(DRAIN_CYCLES - 1);
    localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic REG_GRID_COUNT = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_EVAL      = 2'd1,
        CMD_TRANSPOSE = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_SWEEP,
        ST_DRAIN,
        ST_MERGE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic sweep;
        logic eval_mode;
        logic clear;
        logic rd_issue;
        logic rd_clear;
    } lane_ctl_t;

endpackage

FILE: hw/rtl/sgle_lane.sv
// One lane: grid point bank, accumulator bank and the hat product pipeline.
module sgle_lane #(
    parameter int DEPTH   = 1024,
    parameter int LANES   = 4,
    parameter int LANE_ID = 0,
    parameter int NW      = 13,
    parameter int LSW     = 44
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  sgle_pkg::lane_ctl_t                               ctl,
    input  logic [$clog2(DEPTH)-1:0]                          row,
    input  logic [NW-1:0]                                     n,
    input  logic [sgle_pkg::DIMS-1:0][sgle_pkg::COORD_W-1:0]  x,
    input  logic [sgle_pkg::WEIGHT_W-1:0]                     weight,
    input  logic                                              rd_sel,
    input  logic                                              wr_en,
    input  logic [$clog2(DEPTH)-1:0]                          wr_row,
    input  logic [sgle_pkg::DIMS*sgle_pkg::LEVEL_W-1:0]       wr_level,
    input  logic [sgle_pkg::DIMS*sgle_pkg::INDEX_W-1:0]       wr_index,
    input  logic [sgle_pkg::WEIGHT_W-1:0]                     wr_surplus,
    output logic signed [LSW-1:0]                             lane_sum,
    output logic [sgle_pkg::ACC_W-1:0]                        acc_data
);
    import sgle_pkg::*;

    localparam int RW = $clog2(DEPTH);
    localparam int LB = $clog2(LANES);
    localparam logic [LB-1:0] LID = LB'(LANE_ID);
    localparam int ONE = 1 << COORD_FRAC_BITS;

    function automatic logic [HAT_W-1:0] hat(
        input logic [COORD_W-1:0] xv,
        input logic [LEVEL_W-1:0] l,
        input logic [INDEX_W-1:0] i
    );
        logic [LEVEL_W-1:0] lv;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   ctr;
        logic [POS_W:0]     diff;
        logic [POS_W-1:0]   mag;
        lv   = (l > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : l;
        pos  = POS_W'(xv) << lv;
        ctr  = POS_W'({i, {COORD_FRAC_BITS{1'b0}}});
        diff = {1'b0, pos} - {1'b0, ctr};
        mag  = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];
        return (mag >= POS_W'(ONE)) ? '0 : HAT_W'(POS_W'(ONE) - mag);
    endfunction

    logic [DIMS*LEVEL_W-1:0] level_mem [DEPTH];
    logic [DIMS*INDEX_W-1:0] index_mem [DEPTH];
    logic [WEIGHT_W-1:0]     surplus_mem [DEPTH];
    logic [ACC_W-1:0]        acc_mem [DEPTH];

    logic [DIMS*LEVEL_W-1:0] level_rd_reg;
    logic [DIMS*INDEX_W-1:0] index_rd_reg;
    logic [WEIGHT_W-1:0]     sur1_reg, sur2_reg, sur3_reg, sur4_reg, sur5_reg, sur6_reg;
    logic [RW-1:0]           row1_reg, row2_reg, row3_reg, row4_reg, row5_reg, row6_reg;
    logic [RW-1:0]           row7_reg;
    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic [DIMS-1:0][HAT_W-1:0] h_reg;
    logic [HAT_W-1:0]        h2_3_reg, h2_4_reg, h3_3_reg, h3_4_reg, h4_3_reg, h4_4_reg;
    logic [HAT_W-1:0]        p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [TERM_W-1:0] term_reg;
    logic signed [LSW-1:0]   lsum_reg;
    logic [ACC_W-1:0]        acc_rd_reg;

    logic                    active;
    logic [DIMS-1:0][HAT_W-1:0] h_next;
    logic [2*HAT_W-1:0]      m1, m2, m3, m4;
    logic signed [WEIGHT_W+HAT_W:0] tm;
    logic [WEIGHT_W-1:0]     w_sel;
    logic [RW-1:0]           acc_rd_addr;
    logic                    acc_we;
    logic [RW-1:0]           acc_wr_addr;
    logic [ACC_W-1:0]        acc_wr_data;
    logic signed [VALUE_W:0] acc_sum;
    logic [VALUE_W-1:0]      acc_clip;
    logic                    acc_ovf;

    always_comb
    begin
        active = NW'({row1_reg, LID}) < n;
        for (int d = 0; d < DIMS; d++)
        begin
            h_next[d] = hat(x[d], level_rd_reg[d*LEVEL_W +: LEVEL_W],
                            index_rd_reg[d*INDEX_W +: INDEX_W]);
        end
        m1 = h_reg[0] * h_reg[1];
        m2 = p1_reg * h2_3_reg;
        m3 = p2_reg * h3_4_reg;
        m4 = p3_reg * h4_4_reg;
        w_sel = ctl.eval_mode ? sur6_reg : weight;
        tm = $signed(w_sel) * $signed({1'b0, p4_reg});
        acc_rd_addr = ctl.rd_issue ? row : row6_reg;
        acc_sum = $signed({acc_rd_reg[VALUE_W-1], acc_rd_reg[VALUE_W-1:0]})
                + $signed({{(VALUE_W+1-TERM_W){term_reg[TERM_W-1]}}, term_reg});
        acc_ovf = acc_sum[VALUE_W] != acc_sum[VALUE_W-1];
        acc_clip = !acc_ovf ? acc_sum[VALUE_W-1:0] : (acc_sum[VALUE_W] ? VAL_MIN : VAL_MAX);
        acc_we = 1'b0;
        acc_wr_addr = row;
        acc_wr_data = '0;
        if (ctl.clear || (ctl.rd_clear && rd_sel))
        begin
            acc_we = 1'b1;
        end
        else if (v7_reg && !ctl.eval_mode)
        begin
            acc_we = 1'b1;
            acc_wr_addr = row7_reg;
            acc_wr_data = {acc_rd_reg[VALUE_W] | acc_ovf, acc_clip};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            level_mem[wr_row]   <= wr_level;
            index_mem[wr_row]   <= wr_index;
            surplus_mem[wr_row] <= wr_surplus;
        end
        level_rd_reg <= level_mem[row];
        index_rd_reg <= index_mem[row];
        sur1_reg     <= surplus_mem[row];
        if (acc_we)
        begin
            acc_mem[acc_wr_addr] <= acc_wr_data;
        end
        acc_rd_reg <= acc_mem[acc_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.sweep;
            v2_reg <= v1_reg & active;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row1_reg <= row;
        row2_reg <= row1_reg;
        row3_reg <= row2_reg;
        row4_reg <= row3_reg;
        row5_reg <= row4_reg;
        row6_reg <= row5_reg;
        row7_reg <= row6_reg;
        sur2_reg <= sur1_reg;
        sur3_reg <= sur2_reg;
        sur4_reg <= sur3_reg;
        sur5_reg <= sur4_reg;
        sur6_reg <= sur5_reg;
        h_reg    <= h_next;
        p1_reg   <= m1[COORD_FRAC_BITS +: HAT_W];
        h2_3_reg <= h_reg[2];
        h3_3_reg <= h_reg[3];
        h3_4_reg <= h3_3_reg;
        h2_4_reg <= h_reg[4];
        h4_3_reg <= h2_4_reg;
        h4_4_reg <= h4_3_reg;
        p2_reg   <= m2[COORD_FRAC_BITS +: HAT_W];
        p3_reg   <= m3[COORD_FRAC_BITS +: HAT_W];
        p4_reg   <= m4[COORD_FRAC_BITS +: HAT_W];
        term_reg <= tm[COORD_FRAC_BITS +: TERM_W];
        if (ctl.start)
        begin
            lsum_reg <= '0;
        end
        else if (v7_reg && ctl.eval_mode)
        begin
            lsum_reg <= lsum_reg + LSW'(term_reg);
        end
    end

    assign lane_sum = lsum_reg;
    assign acc_data = acc_rd_reg;

endmodule

FILE: hw/rtl/sgle_merge.sv
// Merge stage: add the lane sums and saturate the total to the result range.
module sgle_merge #(
    parameter int LANES = 4,
    parameter int LSW   = 44
) (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [LSW-1:0]               lane_sum [LANES],
    output logic [sgle_pkg::VALUE_W-1:0]        value,
    output logic                                sat
);
    import sgle_pkg::*;

    localparam int EW = LSW + $clog2(LANES) + VALUE_W + 1;
    localparam logic signed [EW-1:0] EMAX = {{(EW-VALUE_W){1'b0}}, VAL_MAX};
    localparam logic signed [EW-1:0] EMIN = {{(EW-VALUE_W){1'b1}}, VAL_MIN};

    logic signed [EW-1:0]   total;
    logic [VALUE_W-1:0]     value_reg;
    logic                   sat_reg;

    always_comb
    begin
        total = '0;
        for (int k = 0; k < LANES; k++)
        begin
            total = total + EW'(lane_sum[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (total > EMAX)
            begin
                value_reg <= VAL_MAX;
                sat_reg   <= 1'b1;
            end
            else if (total < EMIN)
            begin
                value_reg <= VAL_MIN;
                sat_reg   <= 1'b1;
            end
            else
            begin
                value_reg <= total[VALUE_W-1:0];
                sat_reg   <= 1'b0;
            end
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

FILE: hw/rtl/sparse_grid_linear_eval_unit.sv
// Load is taken in idle; read passes the read-address, read-data and finish states. Evaluate
// sweeps the rows across LANES lane pipelines, then drains, merges and finishes through the
// output stage; transpose sweeps and drains and gives no result. One item in work at a time;
// the next transfer is taken while a result waits in the output register.
// Reset: grid_count returns to 1 and a clearing pass over every accumulator row zeros
// the accumulators; no input transfer is taken during it. Grid tables stay unwritten.
module sparse_grid_linear_eval_unit #(
    parameter int GRID_POINTS = 4096,
    parameter int LANES       = 4
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [sgle_pkg::ADDR_W-1:0]              paddr,
    input  logic [sgle_pkg::DATA_W-1:0]              pwdata,
    output logic [sgle_pkg::DATA_W-1:0]              prdata,
    output logic                                     pready,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [1:0]                               cmd,
    input  logic [sgle_pkg::SLOT_W-1:0]              slot,
    input  logic [sgle_pkg::DIMS*sgle_pkg::LEVEL_W-1:0] level_exps,
    input  logic [sgle_pkg::DIMS*sgle_pkg::INDEX_W-1:0] index_packed,
    input  logic signed [sgle_pkg::WEIGHT_W-1:0]     weight,
    input  logic [sgle_pkg::COORD_W-1:0]             x0,
    input  logic [sgle_pkg::COORD_W-1:0]             x1,
    input  logic [sgle_pkg::COORD_W-1:0]             x2,
    input  logic [sgle_pkg::COORD_W-1:0]             x3,
    input  logic [sgle_pkg::COORD_W-1:0]             x4,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [sgle_pkg::VALUE_W-1:0]      result_value,
    output logic                                     saturated
);
    import sgle_pkg::*;

    localparam int DEPTH = GRID_POINTS / LANES;
    localparam int RW    = $clog2(DEPTH);
    localparam int LB    = $clog2(LANES);
    localparam int PW    = $clog2(GRID_POINTS);
    localparam int NW    = (PW + 1 > GRID_COUNT_W) ? PW + 1 : GRID_COUNT_W;
    localparam int LSW   = TERM_W + RW;
    localparam logic [NW-1:0] GP_N = NW'(GRID_POINTS);

    state_t                  state_reg, state_next;
    logic [RW-1:0]           cnt_reg, cnt_next;
    logic [DRAIN_W-1:0]      drain_reg, drain_next;
    logic [GRID_COUNT_W-1:0] grid_count_reg;
    cmd_t                    cmd_reg;
    logic [RW-1:0]           slot_row_reg;
    logic [LB-1:0]           bank_reg;
    logic                    slot_ok_reg;
    logic [WEIGHT_W-1:0]     weight_reg;
    logic [DIMS-1:0][COORD_W-1:0] x_reg;
    logic [NW-1:0]           n_reg;
    logic [VALUE_W-1:0]      pend_val_reg;
    logic                    pend_sat_reg;
    logic                    out_valid_reg;
    logic [VALUE_W-1:0]      out_val_reg;
    logic                    out_sat_reg;

    lane_ctl_t               ctl;
    logic [RW-1:0]           row;
    logic                    in_accept;
    cmd_t                    in_cmd;
    logic [NW-1:0]           slot_w;
    logic                    slot_ok;
    logic [NW-1:0]           count_w;
    logic                    merge_load;
    logic                    pend_load;
    logic                    out_load;
    logic                    out_free;
    logic                    cfg_write;
    logic [VALUE_W-1:0]      merge_val;
    logic                    merge_sat;
    logic signed [LSW-1:0]   lane_sum [LANES];
    logic [ACC_W-1:0]        acc_data [LANES];
    logic [ACC_W-1:0]        acc_sel;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign in_cmd    = cmd_t'(cmd);
    assign slot_w    = NW'(slot);
    assign slot_ok   = slot_w < GP_N;
    assign count_w   = NW'(grid_count_reg);
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_sel   = acc_data[bank_reg];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_GRID_COUNT) ? DATA_W'(grid_count_reg) : '0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drain_next = drain_reg;
        ctl        = '0;
        ctl.eval_mode = cmd_reg == CMD_EVAL;
        merge_load = 1'b0;
        pend_load  = 1'b0;
        out_load   = 1'b0;
        row        = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == {RW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_accept)
                begin
                    unique case (in_cmd)
                        CMD_LOAD:
                        begin
                            state_next = ST_IDLE;
                        end
                        CMD_EVAL, CMD_TRANSPOSE:
                        begin
                            ctl.start  = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_READ_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ctl.sweep  = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                drain_next = '0;
                if (cnt_reg == {RW{1'b1}})
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = (cmd_reg == CMD_EVAL) ? ST_MERGE : ST_IDLE;
                end
            end
            ST_MERGE:
            begin
                merge_load = 1'b1;
                state_next = ST_FINISH;
            end
            ST_READ_ADDR:
            begin
                row          = slot_row_reg;
                ctl.rd_issue = 1'b1;
                state_next   = ST_READ_DATA;
            end
            ST_READ_DATA:
            begin
                row          = slot_row_reg;
                ctl.rd_clear = 1'b1;
                pend_load    = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            drain_reg      <= '0;
            grid_count_reg <= GRID_COUNT_W'(1);
            out_valid_reg  <= 1'b0;
            cmd_reg        <= CMD_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drain_reg <= drain_next;
            if (cfg_write && paddr[2] == REG_GRID_COUNT)
            begin
                grid_count_reg <= pwdata[GRID_COUNT_W-1:0];
            end
            if (in_accept)
            begin
                cmd_reg <= in_cmd;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            slot_row_reg <= slot_w[LB +: RW];
            bank_reg     <= slot_w[LB-1:0];
            slot_ok_reg  <= slot_ok;
            weight_reg   <= weight;
            x_reg        <= {x4, x3, x2, x1, x0};
            n_reg        <= (count_w > GP_N) ? GP_N : count_w;
        end
        if (pend_load)
        begin
            pend_val_reg <= slot_ok_reg ? acc_sel[VALUE_W-1:0] : '0;
            pend_sat_reg <= slot_ok_reg && acc_sel[VALUE_W];
        end
        if (out_load)
        begin
            out_val_reg <= (cmd_reg == CMD_EVAL) ? merge_val : pend_val_reg;
            out_sat_reg <= (cmd_reg == CMD_EVAL) ? merge_sat : pend_sat_reg;
        end
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        sgle_lane #(
            .DEPTH   (DEPTH),
            .LANES   (LANES),
            .LANE_ID (k),
            .NW      (NW),
            .LSW     (LSW)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .row        (row),
            .n          (n_reg),
            .x          (x_reg),
            .weight     (weight_reg),
            .rd_sel     (slot_ok_reg && bank_reg == LB'(k)),
            .wr_en      (in_accept && in_cmd == CMD_LOAD && slot_ok
                         && slot_w[LB-1:0] == LB'(k)),
            .wr_row     (slot_w[LB +: RW]),
            .wr_level   (level_exps),
            .wr_index   (index_packed),
            .wr_surplus (weight),
            .lane_sum   (lane_sum[k]),
            .acc_data   (acc_data[k])
        );
    end

    sgle_merge #(
        .LANES (LANES),
        .LSW   (LSW)
    ) u_merge (
        .clk      (clk),
        .load     (merge_load),
        .lane_sum (lane_sum),
        .value    (merge_val),
        .sat      (merge_sat)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = out_val_reg;
    assign saturated    = out_sat_reg;

endmodule

FILE: tb/sv/tb_sparse_grid_linear_eval_unit.sv
// Testbench for sparse_grid_linear_eval_unit: random and directed grid, evaluate, transpose and read traffic.
`timescale 1ns / 1ps

module tb_sparse_grid_linear_eval_unit;
    import sgle_pkg::*;

    localparam int NPTS       = 4096;
    localparam int LOADED     = 24;
    localparam int SETTLE     = 1200;
    localparam logic [ADDR_W-1:0] GRID_COUNT_ADDR = ADDR_W'(4 * REG_GRID_COUNT);

    typedef struct {
        cmd_t                  op;
        logic [SLOT_W-1:0]     slot;
        logic [19:0]           lv;
        logic [59:0]           ix;
        logic signed [31:0]    w;
        logic [4:0][15:0]      x;
    } item_t;

    typedef struct {
        longint value;
        bit     sat;
    } result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] cmd = '0;
    logic [SLOT_W-1:0] slot = '0;
    logic [19:0] level_exps = '0;
    logic [59:0] index_packed = '0;
    logic signed [31:0] weight = '0;
    logic [15:0] x0 = '0, x1 = '0, x2 = '0, x3 = '0, x4 = '0;
    logic out_valid;
    logic out_stall = 0;
    logic signed [VALUE_W-1:0] result_value;
    logic saturated;

    sparse_grid_linear_eval_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .slot(slot),
        .level_exps(level_exps), .index_packed(index_packed), .weight(weight),
        .x0(x0), .x1(x1), .x2(x2), .x3(x3), .x4(x4),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_value(result_value), .saturated(saturated)
    );

    item_t   pending_items[$];
    result_t expected_results[$];
    int      errors = 0;
    int      results_seen = 0;

    logic [19:0]        pt_level[NPTS];
    logic [59:0]        pt_index[NPTS];
    logic signed [31:0] pt_surplus[NPTS];
    longint             acc_value[NPTS];
    bit                 acc_clip[NPTS];
    int unsigned        grid_used = 1;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (errors < 30)
            $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    function automatic longint hat_product(int p, logic [4:0][15:0] xv);
        longint prod = 65536;
        longint pos, diff, h, ix;
        int lv;
        for (int d = 0; d < DIMS; d++) begin
            lv = pt_level[p][4*d +: 4];
            if (lv > MAX_LEVEL)
                lv = MAX_LEVEL;
            ix = pt_index[p][12*d +: 12];
            pos = longint'(xv[d]) << lv;
            diff = pos - (ix << COORD_FRAC_BITS);
            if (diff < 0)
                diff = -diff;
            h = 65536 - diff;
            if (h < 0)
                h = 0;
            prod = (prod * h) >> COORD_FRAC_BITS;
        end
        return prod;
    endfunction

    function automatic longint clip48(longint v, inout bit s);
        if (v > 64'sd140737488355327) begin
            s = 1;
            return 64'sd140737488355327;
        end
        if (v < -64'sd140737488355328) begin
            s = 1;
            return -64'sd140737488355328;
        end
        return v;
    endfunction

    function automatic void apply_grid_item(item_t it);
        int n;
        longint sum, t;
        bit s;
        result_t r;
        n = grid_used > NPTS ? NPTS : grid_used;
        sum = 0;
        s = 0;
        case (it.op)
            CMD_LOAD: begin
                pt_level[it.slot] = it.lv;
                pt_index[it.slot] = it.ix;
                pt_surplus[it.slot] = it.w;
            end
            CMD_EVAL: begin
                for (int j = 0; j < n; j++)
                    sum += (longint'(pt_surplus[j]) * hat_product(j, it.x)) >>> COORD_FRAC_BITS;
                r.value = clip48(sum, s);
                r.sat = s;
                expected_results.push_back(r);
            end
            CMD_TRANSPOSE: begin
                for (int j = 0; j < n; j++) begin
                    s = 0;
                    t = (longint'(it.w) * hat_product(j, it.x)) >>> COORD_FRAC_BITS;
                    acc_value[j] = clip48(acc_value[j] + t, s);
                    if (s)
                        acc_clip[j] = 1;
                end
            end
            default: begin
                r.value = acc_value[it.slot];
                r.sat = acc_clip[it.slot];
                acc_value[it.slot] = 0;
                acc_clip[it.slot] = 0;
                expected_results.push_back(r);
            end
        endcase
    endfunction

    // sender: bursts with random gaps
    item_t drv_item;
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (in_valid && !in_stall)
                apply_grid_item(drv_item);
            if (!in_valid || !in_stall) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left > 0 && pending_items.size() > 0) begin
                    drv_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    cmd <= drv_item.op;
                    slot <= drv_item.slot;
                    level_exps <= drv_item.lv;
                    index_packed <= drv_item.ix;
                    weight <= drv_item.w;
                    x0 <= drv_item.x[0];
                    x1 <= drv_item.x[1];
                    x2 <= drv_item.x[2];
                    x3 <= drv_item.x[3];
                    x4 <= drv_item.x[4];
                    burst_left--;
                end else begin
                    in_valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    int hold_left = 0;
    bit held_once = 0;
    int stall_pct = 0;
    int pattern_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with none expected");
                end else begin
                    result_t r;
                    r = expected_results.pop_front();
                    if (result_value !== r.value[VALUE_W-1:0])
                        report_mismatch($sformatf("result_value %0d, want %0d",
                                                  result_value, r.value));
                    if (saturated !== r.sat)
                        report_mismatch($sformatf("saturated %0b, want %0b",
                                                  saturated, r.sat));
                end
                results_seen++;
            end
            if (!held_once && results_seen == 25) begin
                held_once = 1;
                hold_left = 4000;
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(50, 400);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    default: stall_pct = 70;
                endcase
            end
            pattern_left--;
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic item_t blank_item(cmd_t op);
        item_t it;
        it.op = op;
        it.slot = SLOT_W'($urandom);
        it.lv = 20'($urandom);
        it.ix = {28'($urandom), 32'($urandom)};
        it.w = $urandom;
        for (int d = 0; d < DIMS; d++)
            it.x[d] = 16'($urandom);
        return it;
    endfunction

    function automatic item_t shaped_load(int s);
        item_t it;
        int l;
        it = blank_item(CMD_LOAD);
        it.slot = SLOT_W'(s);
        for (int d = 0; d < DIMS; d++) begin
            l = $urandom_range(0, 4);
            it.lv[4*d +: 4] = 4'(l);
            it.ix[12*d +: 12] = (l == 0) ? 12'($urandom_range(0, 1))
                                         : 12'(2 * $urandom_range(0, (1 << (l - 1)) - 1) + 1);
        end
        return it;
    endfunction

    function automatic item_t near_point(cmd_t op, int p);
        item_t it;
        int l, c;
        it = blank_item(op);
        for (int d = 0; d < DIMS; d++) begin
            l = pt_level[p][4*d +: 4];
            if (l > MAX_LEVEL)
                l = MAX_LEVEL;
            c = (int'(pt_index[p][12*d +: 12]) << 16) >> l;
            c = c + $urandom_range(0, 4000) - 2000;
            it.x[d] = (c < 0) ? 16'd0 : (c > 65535) ? 16'hFFFF : 16'(c);
        end
        return it;
    endfunction

    function automatic item_t random_item();
        int k;
        int n;
        k = $urandom_range(0, 99);
        n = grid_used > NPTS ? NPTS : grid_used;
        if (k < 25)
            return near_point(CMD_EVAL, $urandom_range(0, n - 1));
        if (k < 35)
            return blank_item(CMD_EVAL);
        if (k < 50)
            return near_point(CMD_TRANSPOSE, $urandom_range(0, n - 1));
        if (k < 57)
            return blank_item(CMD_TRANSPOSE);
        if (k < 67)
            return shaped_load($urandom_range(0, NPTS - 1));
        if (k < 72)
            return blank_item(CMD_LOAD);
        if (k < 90) begin
            item_t it;
            it = blank_item(CMD_READ);
            it.slot = SLOT_W'($urandom_range(0, n - 1));
            return it;
        end
        return blank_item(CMD_READ);
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_grid_count(input int v);
        wait_idle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= GRID_COUNT_ADDR;
        pwdata <= DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        grid_used = v & 13'h1FFF;
    endtask

    task automatic push_directed(cmd_t op, int s, logic [19:0] lv, logic [59:0] ix,
                                 logic signed [31:0] w, logic [15:0] xa);
        item_t it;
        it.op = op;
        it.slot = SLOT_W'(s);
        it.lv = lv;
        it.ix = ix;
        it.w = w;
        for (int d = 0; d < DIMS; d++)
            it.x[d] = xa;
        pending_items.push_back(it);
    endtask

    initial begin
        for (int i = 0; i < NPTS; i++) begin
            acc_value[i] = 0;
            acc_clip[i] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        write_grid_count(0);
        push_directed(CMD_EVAL, 0, '0, '0, 32'sd1 <<< 24, 16'h8000);
        push_directed(CMD_TRANSPOSE, 0, '0, '0, 32'sh7FFFFFFF, 16'h8000);
        push_directed(CMD_READ, 0, '0, '0, '0, '0);
        push_directed(CMD_READ, 4095, '0, '0, '0, '0);
        for (int i = 0; i < LOADED; i++)
            pending_items.push_back(shaped_load(i));

        write_grid_count(16);
        push_directed(CMD_LOAD, 0, '0, {5{12'd1}}, 32'sh7FFFFFFF, '0);
        push_directed(CMD_LOAD, 1, 20'hFFFFF, 60'hFFF_FFFF_FFFF_FFFF, 32'sh80000000, '0);
        push_directed(CMD_LOAD, 2, {5{4'd12}}, {5{12'd2048}}, 32'sh80000000, '0);
        push_directed(CMD_LOAD, 3, {5{4'd1}}, {5{12'd1}}, -(32'sd1 <<< 24), '0);
        push_directed(CMD_EVAL, 0, '0, '0, '0, 16'h0000);
        push_directed(CMD_EVAL, 0, '0, '0, '0, 16'hFFFF);
        push_directed(CMD_EVAL, 0, '0, '0, '0, 16'h8000);
        push_directed(CMD_EVAL, 0, '0, '0, '0, 16'h4000);
        push_directed(CMD_TRANSPOSE, 0, '0, '0, 32'sh7FFFFFFF, 16'hFFFF);
        push_directed(CMD_TRANSPOSE, 0, '0, '0, 32'sh80000000, 16'h8000);
        push_directed(CMD_TRANSPOSE, 0, '0, '0, 32'sh7FFFFFFF, 16'h8000);
        push_directed(CMD_READ, 0, '0, '0, '0, '0);
        push_directed(CMD_READ, 2, '0, '0, '0, '0);
        push_directed(CMD_READ, 3, '0, '0, '0, '0);
        push_directed(CMD_READ, 2, '0, '0, '0, '0);

        write_grid_count(1);
        for (int i = 0; i < 10; i++)
            pending_items.push_back(random_item());

        for (int seg = 0; seg < 3; seg++) begin
            write_grid_count((seg == 2) ? LOADED : $urandom_range(2, LOADED));
            for (int i = 0; i < 28; i++)
                pending_items.push_back(random_item());
        end

        wait_idle();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
